[hw/rtl/diff_drive_odometry_unit_defines.svh]
// Assertion macros for the odometry unit.
`ifndef DIFF_DRIVE_ODOMETRY_UNIT_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define ODO_ASSERT_IMPLY(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("odometry check failed");

`define ODO_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("odometry check failed");

`else

`define ODO_ASSERT_IMPLY(name, pre, post)
`define ODO_ASSERT_NEXT(name, pre, post)

`endif

`endif

[hw/rtl/odo_pkg.sv]
// Shared types, constants and tables for the odometry unit.
package odo_pkg;

   localparam int CORDIC_STEPS_DEF    = 16;
   localparam int TICK_COUNT_BITS_DEF = 16;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_INDEX_W         = 2;

   localparam logic [31:0] DIST_PER_COUNT_RST    = 32'd749613;
   localparam logic [31:0] HEADING_PER_COUNT_RST = 32'd769716;
   localparam logic [31:0] HEADING_START_RST     = 32'h4000_0000;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [9:0] SPEED_SCALE = 10'd1000;

   typedef enum logic [1:0] {
      OP_LEFT  = 2'd0,
      OP_RIGHT = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIST          = 2'd0,
      CSR_HEADING_RATE  = 2'd1,
      CSR_HEADING_START = 2'd2
   } csr_index_type;

   typedef struct packed {
      opcode_type  opcode;
      logic        forward;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic signed [31:0] left_speed;
      logic signed [31:0] right_speed;
      logic signed [31:0] linear_speed;
      logic signed [31:0] turn_rate;
      logic signed [31:0] position_x;
      logic signed [31:0] position_y;
      logic [31:0]        heading_out;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } back_status_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         5'd24: val = 32'h00000029;
         5'd25: val = 32'h00000014;
         5'd26: val = 32'h0000000A;
         5'd27: val = 32'h00000005;
         5'd28: val = 32'h00000003;
         5'd29: val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

[hw/rtl/odo_front.sv]
// Front end: takes transfers, counts wheel edges, queues tick jobs.
module odo_front #(
   parameter int TICK_COUNT_BITS = odo_pkg::TICK_COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  odo_pkg::req_type                  req_data,
   input  logic                              q_full,
   output logic                              q_push,
   output logic [16+2*TICK_COUNT_BITS-1:0]   q_wdata
);
   localparam int TCB = TICK_COUNT_BITS;
   localparam logic [TCB-1:0] TickMax = {1'b0, {(TCB-1){1'b1}}};
   localparam logic [TCB-1:0] TickMin = {1'b1, {(TCB-1){1'b0}}};

   logic [TCB-1:0] left_ff, left_in;
   logic [TCB-1:0] right_ff, right_in;
   logic           accept;
   logic [15:0]    ms;

   function automatic logic [TCB-1:0] count_step(input logic [TCB-1:0] c, input logic up);
      logic [TCB-1:0] r;
      if (up) begin
         r = (c != TickMax) ? c + 1'b1 : c;
      end else begin
         r = (c != TickMin) ? c - 1'b1 : c;
      end
      return r;
   endfunction

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign ms        = (req_data.elapsed_ms == 16'd0) ? 16'd1 : req_data.elapsed_ms;
   assign q_wdata   = {ms, left_ff, right_ff};

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      q_push   = 1'b0;
      if (accept) begin
         unique case (req_data.opcode)
            odo_pkg::OP_LEFT:  left_in = count_step(left_ff, req_data.forward);
            odo_pkg::OP_RIGHT: right_in = count_step(right_ff, req_data.forward);
            odo_pkg::OP_TICK: begin
               q_push   = 1'b1;
               left_in  = '0;
               right_in = '0;
            end
            odo_pkg::OP_NONE: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= '0;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

endmodule

[hw/rtl/odo_queue.sv]
// Short job queue between front end and back end.
module odo_queue #(
   parameter int WIDTH = 48,
   parameter int DEPTH = odo_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);
   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTRW-1:0] ptr_next(input logic [PTRW-1:0] p);
      return (p == PTRW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[hw/rtl/odo_back.sv]
// Back end: speeds, turn rate, CORDIC and position update for each tick job.
module odo_back #(
   parameter int CORDIC_STEPS    = odo_pkg::CORDIC_STEPS_DEF,
   parameter int TICK_COUNT_BITS = odo_pkg::TICK_COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   output logic                             q_pop,
   input  logic [16+2*TICK_COUNT_BITS-1:0]  q_rdata,
   input  logic [31:0]                      dist_per_count,
   input  logic [31:0]                      heading_per_count,
   input  logic                             heading_load,
   input  logic [31:0]                      heading_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output odo_pkg::rsp_type                 rsp_data,
   output odo_pkg::back_status_type         status
);
   localparam int TCB   = TICK_COUNT_BITS;
   localparam int JOB_W = 16 + 2 * TCB;
   localparam int PW    = (TCB + 43 > 64) ? TCB + 43 : 64;
   localparam int BW    = (TCB + 1 > 32) ? TCB + 1 : 32;
   localparam int CW    = $clog2(CORDIC_STEPS + 1);

   typedef enum logic [15:0] {
      S_IDLE  = 16'b0000_0000_0000_0001,
      S_START = 16'b0000_0000_0000_0010,
      S_LMUL1 = 16'b0000_0000_0000_0100,
      S_LMUL2 = 16'b0000_0000_0000_1000,
      S_LDIV  = 16'b0000_0000_0001_0000,
      S_RMUL1 = 16'b0000_0000_0010_0000,
      S_RMUL2 = 16'b0000_0000_0100_0000,
      S_RDIV  = 16'b0000_0000_1000_0000,
      S_TMUL1 = 16'b0000_0001_0000_0000,
      S_TMUL2 = 16'b0000_0010_0000_0000,
      S_TDIV  = 16'b0000_0100_0000_0000,
      S_SMUL  = 16'b0000_1000_0000_0000,
      S_CORD  = 16'b0001_0000_0000_0000,
      S_XMUL  = 16'b0010_0000_0000_0000,
      S_YMUL  = 16'b0100_0000_0000_0000,
      S_DONE  = 16'b1000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]    ms_ff, ms_in;
   logic [TCB-1:0] dl_ff, dl_in, dr_ff, dr_in;

   logic [PW-1:0]  mul_a_ff, mul_a_in, mul_p_ff, mul_p_in;
   logic [BW-1:0]  mul_b_ff, mul_b_in;
   logic [15:0]    div_rem_ff, div_rem_in;
   logic [31:0]    div_d_ff, div_d_in;
   logic [5:0]     div_cnt_ff, div_cnt_in;
   logic           div_sat_ff, div_sat_in, div_neg_ff, div_neg_in;

   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [1:0]     quad_ff, quad_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   logic [31:0]    ls_ff, ls_in, rs_ff, rs_in, turn_ff, turn_in, delta_ff, delta_in;
   logic [30:0]    trav_ff, trav_in;
   logic           trav_neg_ff, trav_neg_in;
   logic [31:0]    pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, heading_ff, heading_in;

   logic             rsp_valid_ff, rsp_valid_in;
   odo_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // derived values
   logic [TCB-1:0] dl_mag, dr_mag;
   logic [TCB:0]   sum_w, diff_w, sum_mag, diff_mag;
   logic           mul_done, div_done, cord_done, rsp_free;
   logic [16:0]    rem2;
   logic           rem_ge;
   logic [31:0]    div_q, div_v, div_lim, div_result;
   logic           div_load;
   logic [PW-1:0]  div_src;
   logic           div_src_neg;
   logic signed [33:0] xs, ys, atan_w, cos_w, sin_w;
   logic [33:0]    cos_abs, sin_abs;
   logic [31:0]    hq, rest;
   logic [63:0]    p64, sp;
   logic           step_neg;
   logic [31:0]    step;
   logic signed [32:0] lin_sum, lin_adj;

   assign dl_mag   = dl_ff[TCB-1] ? (~dl_ff + 1'b1) : dl_ff;
   assign dr_mag   = dr_ff[TCB-1] ? (~dr_ff + 1'b1) : dr_ff;
   assign sum_w    = {dl_ff[TCB-1], dl_ff} + {dr_ff[TCB-1], dr_ff};
   assign diff_w   = {dr_ff[TCB-1], dr_ff} - {dl_ff[TCB-1], dl_ff};
   assign sum_mag  = sum_w[TCB] ? (~sum_w + 1'b1) : sum_w;
   assign diff_mag = diff_w[TCB] ? (~diff_w + 1'b1) : diff_w;

   assign mul_done  = (mul_b_ff == '0);
   assign div_done  = (div_cnt_ff == 6'd32);
   assign cord_done = (cnt_ff == CW'(CORDIC_STEPS));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // divider: one quotient bit per cycle
   assign rem2       = {div_rem_ff, div_d_ff[31]};
   assign rem_ge     = (rem2 >= {1'b0, ms_ff});
   assign div_q      = div_d_ff;
   assign div_lim    = div_neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
   assign div_v      = (div_sat_ff || div_q > div_lim) ? div_lim : div_q;
   assign div_result = div_neg_ff ? (~div_v + 32'd1) : div_v;

   // CORDIC
   assign xs     = cx_ff >>> cnt_ff;
   assign ys     = cy_ff >>> cnt_ff;
   assign atan_w = {2'b00, odo_pkg::atan_entry(5'(cnt_ff))};
   assign hq     = heading_ff + 32'h2000_0000;
   assign rest   = heading_ff - {hq[31:30], 30'd0};

   always_comb begin
      unique case (quad_ff)
         2'd0: begin cos_w = cx_ff;  sin_w = cy_ff;  end
         2'd1: begin cos_w = -cy_ff; sin_w = cx_ff;  end
         2'd2: begin cos_w = -cx_ff; sin_w = -cy_ff; end
         2'd3: begin cos_w = cy_ff;  sin_w = -cx_ff; end
      endcase
   end

   assign cos_abs = cos_w[33] ? 34'(-cos_w) : 34'(cos_w);
   assign sin_abs = sin_w[33] ? 34'(-sin_w) : 34'(sin_w);

   // position step: floor(travel * trig / 2^30)
   assign p64  = mul_p_ff[63:0];
   assign sp   = step_neg ? (~p64 + 64'd1) : p64;
   assign step = sp[61:30];

   assign lin_sum = {ls_ff[31], ls_ff} + {rs_ff[31], rs_ff};
   assign lin_adj = lin_sum + {32'd0, lin_sum[32]};

   always_comb begin
      state_in     = state_ff;
      ms_in        = ms_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      q_pop        = 1'b0;
      mul_a_in     = {mul_a_ff[PW-2:0], 1'b0};
      mul_b_in     = {1'b0, mul_b_ff[BW-1:1]};
      mul_p_in     = mul_b_ff[0] ? mul_p_ff + mul_a_ff : mul_p_ff;
      div_rem_in   = div_rem_ff;
      div_d_in     = div_d_ff;
      div_cnt_in   = div_cnt_ff;
      div_sat_in   = div_sat_ff;
      div_neg_in   = div_neg_ff;
      div_load     = 1'b0;
      div_src      = mul_p_ff;
      div_src_neg  = 1'b0;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      quad_in      = quad_ff;
      cnt_in       = cnt_ff;
      ls_in        = ls_ff;
      rs_in        = rs_ff;
      turn_in      = turn_ff;
      delta_in     = delta_ff;
      trav_in      = trav_ff;
      trav_neg_in  = trav_neg_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      heading_in   = heading_ff;
      step_neg     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (!div_done) begin
         div_rem_in = rem_ge ? 16'(rem2 - {1'b0, ms_ff}) : rem2[15:0];
         div_d_in   = {div_d_ff[30:0], rem_ge};
         div_cnt_in = div_cnt_ff + 6'd1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               ms_in    = q_rdata[JOB_W-1 -: 16];
               dl_in    = q_rdata[2*TCB-1 -: TCB];
               dr_in    = q_rdata[TCB-1:0];
               state_in = S_START;
            end
         end
         S_START: begin
            mul_a_in = PW'(dist_per_count);
            mul_b_in = BW'(dl_mag);
            mul_p_in = '0;
            state_in = S_LMUL1;
         end
         S_LMUL1, S_RMUL1, S_TMUL1: begin
            if (mul_done) begin
               if (state_ff == S_TMUL1) begin
                  delta_in = diff_w[TCB] ? (~mul_p_ff[31:0] + 32'd1) : mul_p_ff[31:0];
                  state_in = S_TMUL2;
               end else if (state_ff == S_LMUL1) begin
                  state_in = S_LMUL2;
               end else begin
                  state_in = S_RMUL2;
               end
               mul_a_in = mul_p_ff;
               mul_b_in = BW'(odo_pkg::SPEED_SCALE);
               mul_p_in = '0;
            end
         end
         S_LMUL2: begin
            if (mul_done) begin
               div_load    = 1'b1;
               div_src     = mul_p_ff >> 16;
               div_src_neg = dl_ff[TCB-1];
               state_in    = S_LDIV;
            end
         end
         S_RMUL2: begin
            if (mul_done) begin
               div_load    = 1'b1;
               div_src     = mul_p_ff >> 16;
               div_src_neg = dr_ff[TCB-1];
               state_in    = S_RDIV;
            end
         end
         S_TMUL2: begin
            if (mul_done) begin
               div_load    = 1'b1;
               div_src     = mul_p_ff;
               div_src_neg = diff_w[TCB];
               state_in    = S_TDIV;
            end
         end
         S_LDIV: begin
            if (div_done) begin
               ls_in    = div_result;
               mul_a_in = PW'(dist_per_count);
               mul_b_in = BW'(dr_mag);
               mul_p_in = '0;
               state_in = S_RMUL1;
            end
         end
         S_RDIV: begin
            if (div_done) begin
               rs_in    = div_result;
               mul_a_in = PW'(heading_per_count);
               mul_b_in = BW'(diff_mag);
               mul_p_in = '0;
               state_in = S_TMUL1;
            end
         end
         S_TDIV: begin
            if (div_done) begin
               turn_in  = div_result;
               mul_a_in = PW'(dist_per_count);
               mul_b_in = BW'(sum_mag);
               mul_p_in = '0;
               state_in = S_SMUL;
            end
         end
         S_SMUL: begin
            if (mul_done) begin
               // mean travel in 2^-16 m, saturated
               trav_in     = (|mul_p_ff[PW-1:48]) ? 31'h7FFF_FFFF : mul_p_ff[47:17];
               trav_neg_in = sum_w[TCB];
               cx_in       = odo_pkg::CORDIC_GAIN;
               cy_in       = '0;
               cz_in       = {{2{rest[31]}}, rest};
               quad_in     = hq[31:30];
               cnt_in      = '0;
               state_in    = S_CORD;
            end
         end
         S_CORD: begin
            if (cord_done) begin
               mul_a_in = PW'(trav_ff);
               mul_b_in = BW'(cos_abs[31:0]);
               mul_p_in = '0;
               state_in = S_XMUL;
            end else begin
               if (!cz_ff[33]) begin
                  cx_in = cx_ff - ys;
                  cy_in = cy_ff + xs;
                  cz_in = cz_ff - atan_w;
               end else begin
                  cx_in = cx_ff + ys;
                  cy_in = cy_ff - xs;
                  cz_in = cz_ff + atan_w;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_XMUL: begin
            step_neg = trav_neg_ff ^ cos_w[33];
            if (mul_done) begin
               pos_x_in = pos_x_ff + step;
               mul_a_in = PW'(trav_ff);
               mul_b_in = BW'(sin_abs[31:0]);
               mul_p_in = '0;
               state_in = S_YMUL;
            end
         end
         S_YMUL: begin
            step_neg = trav_neg_ff ^ sin_w[33];
            if (mul_done) begin
               pos_y_in   = pos_y_ff + step;
               heading_in = heading_ff + delta_ff;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.left_speed   = ls_ff;
               rsp_data_in.right_speed  = rs_ff;
               rsp_data_in.linear_speed = lin_adj[32:1];
               rsp_data_in.turn_rate    = turn_ff;
               rsp_data_in.position_x   = pos_x_ff;
               rsp_data_in.position_y   = pos_y_ff;
               rsp_data_in.heading_out  = heading_ff;
               state_in                 = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (div_load) begin
         div_sat_in = (div_src[PW-1:32] >= (PW-32)'(ms_ff));
         div_rem_in = div_src[47:32];
         div_d_in   = div_src[31:0];
         div_cnt_in = '0;
         div_neg_in = div_src_neg;
      end

      if (heading_load) begin
         heading_in = heading_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= 6'd32;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= odo_pkg::HEADING_START_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ms_ff       <= ms_in;
      dl_ff       <= dl_in;
      dr_ff       <= dr_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_p_ff    <= mul_p_in;
      div_rem_ff  <= div_rem_in;
      div_d_ff    <= div_d_in;
      div_sat_ff  <= div_sat_in;
      div_neg_ff  <= div_neg_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      quad_ff     <= quad_in;
      cnt_ff      <= cnt_in;
      ls_ff       <= ls_in;
      rs_ff       <= rs_in;
      turn_ff     <= turn_in;
      delta_ff    <= delta_in;
      trav_ff     <= trav_in;
      trav_neg_ff <= trav_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign status.busy = (state_ff != S_IDLE);
   assign status.done = (state_ff == S_DONE) && rsp_free;

endmodule

[hw/rtl/diff_drive_odometry_unit.sv]
// Top level of the differential-drive odometry unit.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   odo_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall   odo_pkg::rsp_type
//   csr      in         csr_wr_en             csr_index, csr_wdata
//
// Wheel edges are counted in front-end registers; ticks queue (two deep) for the back end.
// The time a tick takes is set by the shared shift-add multiplier
// (one multiplier bit per cycle), the one-bit-per-cycle divider and CORDIC_STEPS.
// req_stall rises only while the tick queue is full; rsp holds in its output register.
// Reset is synchronous; heading restarts at the heading_start reset value.
`include "diff_drive_odometry_unit_defines.svh"

module diff_drive_odometry_unit #(
   parameter int CORDIC_STEPS    = odo_pkg::CORDIC_STEPS_DEF,
   parameter int TICK_COUNT_BITS = odo_pkg::TICK_COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  odo_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output odo_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [odo_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_wdata
);
   localparam int JOB_W = 16 + 2 * TICK_COUNT_BITS;

   logic [31:0]              dpc_ff, dpc_in, hpc_ff, hpc_in;
   logic                     heading_load;
   logic                     q_push, q_pop, q_full, q_empty;
   logic [JOB_W-1:0]         q_wdata, q_rdata;
   odo_pkg::back_status_type back_status;

   assign heading_load = csr_wr_en && (csr_index == odo_pkg::CSR_HEADING_START);

   always_comb begin
      dpc_in = dpc_ff;
      hpc_in = hpc_ff;
      if (csr_wr_en && csr_index == odo_pkg::CSR_DIST) begin
         dpc_in = csr_wdata;
      end
      if (csr_wr_en && csr_index == odo_pkg::CSR_HEADING_RATE) begin
         hpc_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff <= odo_pkg::DIST_PER_COUNT_RST;
         hpc_ff <= odo_pkg::HEADING_PER_COUNT_RST;
      end else begin
         dpc_ff <= dpc_in;
         hpc_ff <= hpc_in;
      end
   end

   odo_front #(
      .TICK_COUNT_BITS(TICK_COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   odo_queue #(
      .WIDTH (JOB_W),
      .DEPTH (odo_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   odo_back #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .TICK_COUNT_BITS (TICK_COUNT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .q_rdata           (q_rdata),
      .dist_per_count    (dpc_ff),
      .heading_per_count (hpc_ff),
      .heading_load      (heading_load),
      .heading_value     (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .status            (back_status)
   );

   `ODO_ASSERT_NEXT(a_tick_queued, req_valid && !req_stall && req_data.opcode == odo_pkg::OP_TICK, !q_empty)
   `ODO_ASSERT_IMPLY(a_rsp_from_back, $rose(rsp_valid), $past(back_status.done))
   `ODO_ASSERT_IMPLY(a_full_means_busy, q_full, back_status.busy || q_pop)

endmodule

[sim/diff_drive_odometry_unit_checker.sv]
// Checker for the odometry unit: predicts each tick result and compares it.
`timescale 1ns / 1ps

module diff_drive_odometry_unit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  odo_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  odo_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [odo_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata,
   output int                              failures,
   output int                              outstanding
);

   localparam longint COUNT_MAX = (longint'(1) <<< (odo_pkg::TICK_COUNT_BITS_DEF - 1)) - 1;
   localparam longint COUNT_MIN = -(longint'(1) <<< (odo_pkg::TICK_COUNT_BITS_DEF - 1));

   localparam logic [31:0] ARC_STEP [30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   logic [31:0]      dist_scale;
   logic [31:0]      turn_scale;
   longint           left_count;
   longint           right_count;
   logic [31:0]      pos_x;
   logic [31:0]      pos_y;
   logic [31:0]      heading;
   odo_pkg::rsp_type pending_odometry [$];

   function automatic longint step_count(longint c, logic up);
      if (up) return (c < COUNT_MAX) ? c + 1 : c;
      return (c > COUNT_MIN) ? c - 1 : c;
   endfunction

   function automatic logic [31:0] rate_per_second(longint unsigned mag, longint unsigned div,
                                                   logic neg);
      longint unsigned q;
      longint unsigned r;
      longint unsigned lim;
      longint unsigned v;
      logic [31:0] v32;
      q = mag / div;
      r = mag % div;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (q >= 64'd4294967296) v = lim;
      else v = q * 1000 + (r * 1000) / div;
      if (v > lim) v = lim;
      v32 = v[31:0];
      return neg ? -v32 : v32;
   endfunction

   task automatic heading_trig(input logic [31:0] angle, output longint c, output longint s);
      logic [31:0] shifted;
      logic [1:0]  quad;
      logic [31:0] rest;
      longint      x;
      longint      y;
      longint      z;
      longint      nx;
      shifted = angle + 32'h20000000;
      quad = shifted[31:30];
      rest = angle - {quad, 30'd0};
      z = longint'($signed(rest));
      x = longint'(odo_pkg::CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < odo_pkg::CORDIC_STEPS_DEF && i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(ARC_STEP[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(ARC_STEP[i]);
         end
         x = nx;
      end
      case (quad)
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   task automatic integrate_tick(input logic [15:0] elapsed);
      longint unsigned  ms;
      longint unsigned  mag;
      longint           lin;
      longint           diff;
      longint           sum;
      longint           travel;
      longint           c;
      longint           s;
      longint           step;
      logic [31:0]      delta;
      odo_pkg::rsp_type r;
      ms = (elapsed == 0) ? 1 : elapsed;
      r.left_speed = rate_per_second((left_count < 0 ? -left_count : left_count) * dist_scale,
                                     ms * 65536, left_count < 0);
      r.right_speed = rate_per_second((right_count < 0 ? -right_count : right_count) * dist_scale,
                                      ms * 65536, right_count < 0);
      lin = (longint'(r.left_speed) + longint'(r.right_speed)) / 2;
      r.linear_speed = lin[31:0];
      diff = right_count - left_count;
      mag = (diff < 0 ? -diff : diff) * longint'(turn_scale);
      r.turn_rate = rate_per_second(mag, ms, diff < 0);
      delta = mag[31:0];
      if (diff < 0) delta = -delta;
      sum = left_count + right_count;
      mag = (((sum < 0 ? -sum : sum) * longint'(dist_scale)) / 2) >> 16;
      if (mag > 64'd2147483647) mag = 64'd2147483647;
      travel = (sum < 0) ? -longint'(mag) : longint'(mag);
      heading_trig(heading, c, s);
      step = (travel * c) >>> 30;
      pos_x = pos_x + step[31:0];
      step = (travel * s) >>> 30;
      pos_y = pos_y + step[31:0];
      heading = heading + delta;
      left_count = 0;
      right_count = 0;
      r.position_x = pos_x;
      r.position_y = pos_y;
      r.heading_out = heading;
      pending_odometry.push_back(r);
   endtask

   task automatic report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
      failures++;
   endtask

   always @(posedge clock) begin
      odo_pkg::rsp_type want;
      if (reset) begin
         dist_scale = odo_pkg::DIST_PER_COUNT_RST;
         turn_scale = odo_pkg::HEADING_PER_COUNT_RST;
         heading = odo_pkg::HEADING_START_RST;
         left_count = 0;
         right_count = 0;
         pos_x = 0;
         pos_y = 0;
         pending_odometry.delete();
         failures = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               odo_pkg::CSR_DIST: dist_scale = csr_wdata;
               odo_pkg::CSR_HEADING_RATE: turn_scale = csr_wdata;
               odo_pkg::CSR_HEADING_START: heading = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_data.opcode)
               odo_pkg::OP_LEFT: left_count = step_count(left_count, req_data.forward);
               odo_pkg::OP_RIGHT: right_count = step_count(right_count, req_data.forward);
               odo_pkg::OP_TICK: integrate_tick(req_data.elapsed_ms);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_odometry.size() == 0) begin
               $display("%0t: unexpected transfer, expected none actual %h", $time, rsp_data);
               failures++;
            end else begin
               want = pending_odometry.pop_front();
               if (rsp_data.left_speed !== want.left_speed)
                  report("left_speed", want.left_speed, rsp_data.left_speed);
               if (rsp_data.right_speed !== want.right_speed)
                  report("right_speed", want.right_speed, rsp_data.right_speed);
               if (rsp_data.linear_speed !== want.linear_speed)
                  report("linear_speed", want.linear_speed, rsp_data.linear_speed);
               if (rsp_data.turn_rate !== want.turn_rate)
                  report("turn_rate", want.turn_rate, rsp_data.turn_rate);
               if (rsp_data.position_x !== want.position_x)
                  report("position_x", want.position_x, rsp_data.position_x);
               if (rsp_data.position_y !== want.position_y)
                  report("position_y", want.position_y, rsp_data.position_y);
               if (rsp_data.heading_out !== want.heading_out)
                  report("heading_out", want.heading_out, rsp_data.heading_out);
            end
         end
      end
      outstanding = pending_odometry.size();
   end

endmodule

[sim/diff_drive_odometry_unit_test.sv]
// Testbench top for the odometry unit: stimulus, idling and verdict.
`timescale 1ns / 1ps

module diff_drive_odometry_unit_test;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE = 500;
   localparam int BURST_LEN = 33;

   logic                            clock = 0;
   logic                            reset = 1;
   logic                            req_valid = 0;
   logic                            req_stall;
   odo_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1;
   odo_pkg::rsp_type                rsp_data;
   logic                            csr_wr_en = 0;
   logic [odo_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]                     csr_wdata = '0;
   int                              failures;
   int                              outstanding;
   int                              cycles = 0;
   bit                              no_gaps = 0;
   bit                              long_hold = 0;
   int                              calm_send = 0;
   int                              calm_recv = 0;

   diff_drive_odometry_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   diff_drive_odometry_unit_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .outstanding(outstanding)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("diff_drive_odometry_unit_test NOT OK");
         $finish;
      end
   end

   function automatic int draw_wait(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   // receiver: random stall before each transfer, one long hold on request
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            n = 3000;
            long_hold = 0;
         end else begin
            n = draw_wait(calm_recv);
         end
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_item(input odo_pkg::opcode_type op, input logic fwd,
                            input logic [15:0] ms);
      int gap;
      gap = no_gaps ? 0 : draw_wait(calm_send);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{opcode: op, forward: fwd, elapsed_ms: ms};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input odo_pkg::csr_index_type idx, input logic [31:0] value);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic burst(input odo_pkg::opcode_type op, input logic fwd, input int count);
      no_gaps = 1;
      repeat (count) send_item(op, fwd, 16'($urandom));
      no_gaps = 0;
   endtask

   function automatic logic [15:0] draw_ms;
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'hFFFF;
         default: return 16'($urandom_range(1, 100));
      endcase
   endfunction

   task automatic random_run(input int items);
      int done;
      int k;
      int bias_l;
      int bias_r;
      done = 0;
      while (done < items) begin
         if ($urandom_range(0, 99) < 85) begin
            k = $urandom_range(0, 40);
            bias_l = $urandom_range(0, 100);
            bias_r = $urandom_range(0, 100);
            repeat (k) begin
               if ($urandom_range(0, 1))
                  send_item(odo_pkg::OP_LEFT, $urandom_range(0, 99) < bias_l, 16'($urandom));
               else
                  send_item(odo_pkg::OP_RIGHT, $urandom_range(0, 99) < bias_r, 16'($urandom));
            end
            send_item(odo_pkg::OP_TICK, 1'($urandom), draw_ms());
            done += k + 1;
         end else begin
            case ($urandom_range(0, 3))
               0: send_item(odo_pkg::OP_NONE, 1'($urandom), 16'($urandom));
               1: begin
                  send_item(odo_pkg::OP_TICK, 1'($urandom), 16'd0);
                  done++;
               end
               default: begin
                  send_item(odo_pkg::opcode_type'($urandom_range(0, 1)), 1'($urandom),
                            16'($urandom));
                  done++;
               end
            endcase
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed, reset settings
      send_item(odo_pkg::OP_TICK, 0, 16'd1);
      send_item(odo_pkg::OP_LEFT, 1, 16'hFFFF);
      send_item(odo_pkg::OP_RIGHT, 0, 16'h0000);
      send_item(odo_pkg::OP_TICK, 1, 16'hFFFF);
      send_item(odo_pkg::OP_NONE, 1, 16'hFFFF);
      send_item(odo_pkg::OP_NONE, 0, 16'h0000);
      send_item(odo_pkg::OP_RIGHT, 1, 16'h5555);
      send_item(odo_pkg::OP_RIGHT, 1, 16'hAAAA);
      send_item(odo_pkg::OP_TICK, 0, 16'd0);
      burst(odo_pkg::OP_LEFT, 1, BURST_LEN);
      burst(odo_pkg::OP_RIGHT, 0, BURST_LEN);
      send_item(odo_pkg::OP_TICK, 0, 16'd1);
      random_run(300);

      // receiver holds off while ticks keep coming
      long_hold = 1;
      repeat (10) begin
         send_item(odo_pkg::OP_LEFT, 1, 16'($urandom));
         send_item(odo_pkg::OP_TICK, 1, 16'($urandom_range(1, 50)));
      end
      drain();

      // smallest scales, heading from zero
      write_csr(odo_pkg::CSR_DIST, 32'd1);
      write_csr(odo_pkg::CSR_HEADING_RATE, 32'd1);
      write_csr(odo_pkg::CSR_HEADING_START, 32'd0);
      random_run(300);

      // largest scales: speeds and turn rate saturate
      write_csr(odo_pkg::CSR_DIST, 32'hFFFF_FFFF);
      write_csr(odo_pkg::CSR_HEADING_RATE, 32'hFFFF_FFFF);
      write_csr(odo_pkg::CSR_HEADING_START, 32'hFFFF_FFFF);
      burst(odo_pkg::OP_LEFT, 0, BURST_LEN);
      burst(odo_pkg::OP_RIGHT, 1, BURST_LEN);
      send_item(odo_pkg::OP_TICK, 1, 16'd1);
      burst(odo_pkg::OP_LEFT, 1, BURST_LEN);
      burst(odo_pkg::OP_RIGHT, 1, BURST_LEN);
      send_item(odo_pkg::OP_TICK, 0, 16'd1);
      random_run(300);

      write_csr(odo_pkg::CSR_DIST, $urandom);
      write_csr(odo_pkg::CSR_HEADING_RATE, $urandom);
      write_csr(odo_pkg::CSR_HEADING_START, $urandom);
      random_run(300);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("diff_drive_odometry_unit_test OK");
      end else begin
         $display("diff_drive_odometry_unit_test NOT OK");
      end
      $finish;
   end

endmodule
